[hw/rtl/utt_pkg.sv]
// ----------------------------------------------------------------------------
// utt_pkg
// Shared types and constants of the UTF-16LE to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package utt_pkg;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_ODD_LEN  = 3'd1,
    ERR_TRUNC    = 3'd2,
    ERR_BAD_PAIR = 3'd3,
    ERR_LONE_LOW = 3'd4
  } err_code_t;

  localparam logic [15:0] SURR_HI_MIN = 16'hd800;
  localparam logic [15:0] SURR_HI_MAX = 16'hdbff;
  localparam logic [15:0] SURR_LO_MIN = 16'hdc00;
  localparam logic [15:0] SURR_LO_MAX = 16'hdfff;

  localparam logic [20:0] CP_1B_MAX = 21'h00007f;
  localparam logic [20:0] CP_2B_MAX = 21'h0007ff;
  localparam logic [20:0] CP_3B_MAX = 21'h00ffff;
  localparam logic [10:0] PLANE_ADD = 11'd64;  // 0x10000 >> 10

  localparam logic [7:0] LEAD_2B = 8'hc0;
  localparam logic [7:0] LEAD_3B = 8'he0;
  localparam logic [7:0] LEAD_4B = 8'hf0;
  localparam logic [7:0] CONT_B  = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  utf8_byte;
    logic        run_last;
    logic        text_done;
    logic [2:0]  error_code;
    logic [31:0] error_position;
  } out_item_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;   // bytes[0] leaves first
    logic [1:0]      last;    // byte count minus one
  } utf8_seq_t;

  function automatic utf8_seq_t utf8_encode(input logic [20:0] cp);
    utf8_seq_t s;
    s = '0;
    if (cp <= CP_1B_MAX) begin
      s.bytes[0] = cp[7:0];
      s.last     = 2'd0;
    end else if (cp <= CP_2B_MAX) begin
      s.bytes[0] = LEAD_2B | {3'b000, cp[10:6]};
      s.bytes[1] = CONT_B | {2'b00, cp[5:0]};
      s.last     = 2'd1;
    end else if (cp <= CP_3B_MAX) begin
      s.bytes[0] = LEAD_3B | {4'b0000, cp[15:12]};
      s.bytes[1] = CONT_B | {2'b00, cp[11:6]};
      s.bytes[2] = CONT_B | {2'b00, cp[5:0]};
      s.last     = 2'd2;
    end else begin
      s.bytes[0] = LEAD_4B | {5'b00000, cp[20:18]};
      s.bytes[1] = CONT_B | {2'b00, cp[17:12]};
      s.bytes[2] = CONT_B | {2'b00, cp[11:6]};
      s.bytes[3] = CONT_B | {2'b00, cp[5:0]};
      s.last     = 2'd3;
    end
    return s;
  endfunction

endpackage

[hw/rtl/utt_stream_if.sv]
// ----------------------------------------------------------------------------
// utt_in_if / utt_out_if
// Valid/ready channels carrying input bytes and UTF-8 result requests.
// ----------------------------------------------------------------------------
interface utt_in_if;
  logic              valid;
  logic              ready;
  utt_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface utt_out_if;
  logic               valid;
  logic               ready;
  utt_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/utf16le_to_utf8_transcoder.sv]
// ----------------------------------------------------------------------------
// utf16le_to_utf8_transcoder
// Pairs UTF-16LE bytes into code units, joins surrogates and emits UTF-8
// bytes, or one error request with its position.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  in_chan   in   valid/ready      data_byte, final_byte
//  out_chan  out  valid/ready      utf8_byte, run_last, text_done, error_*
//  cfg_*     in   cfg_we           cfg_wdata -> text_start
//
//  An input byte is decoded in the cycle it is accepted and its 0..4 result
//  requests are loaded into the output register, which then sends one per
//  cycle while out_chan.ready is high. The next byte is accepted in the cycle
//  the last pending request leaves. Reset is synchronous: text state and
//  text_start clear to zero.
// ----------------------------------------------------------------------------
module utf16le_to_utf8_transcoder (
  input  logic              clk,
  input  logic              rst_n,
  utt_in_if.sink            in_chan,
  utt_out_if.source         out_chan,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata
);

  // text state
  logic [7:0]  held_r, held_nxt;
  logic        odd_r, odd_nxt;
  logic        hp_r, hp_nxt;
  logic [9:0]  hb_r, hb_nxt;
  logic [31:0] off_r, off_nxt;
  logic        skip_r, skip_nxt;
  logic [31:0] start_r;

  // output register
  logic            bv_r, bv_nxt;
  logic [1:0]      rem_r, rem_nxt;
  logic [3:0][7:0] bytes_r, bytes_nxt;
  logic            done_r, done_nxt;
  logic [2:0]      code_r, code_nxt;
  logic [31:0]     pos_r, pos_nxt;

  logic in_acc, out_acc;
  logic [7:0]  b;
  logic        fin;
  logic [15:0] unit;
  logic        is_hi, is_lo;
  logic [20:0] cp;
  utt_pkg::utf8_seq_t seq;
  logic        has_res;
  logic        enc;
  logic        fail;
  utt_pkg::err_code_t fcode;
  logic [31:0] foff;

  assign b    = in_chan.data.data_byte;
  assign fin  = in_chan.data.final_byte;
  assign unit = {b, held_r};
  assign is_hi = (unit >= utt_pkg::SURR_HI_MIN) && (unit <= utt_pkg::SURR_HI_MAX);
  assign is_lo = (unit >= utt_pkg::SURR_LO_MIN) && (unit <= utt_pkg::SURR_LO_MAX);

  assign in_chan.ready = !bv_r || (out_chan.ready && rem_r == 2'd0);
  assign in_acc  = in_chan.valid && in_chan.ready;
  assign out_acc = bv_r && out_chan.ready;

  always_comb begin
    cp = hp_r ? {({1'b0, hb_r} + utt_pkg::PLANE_ADD), unit[9:0]} : {5'd0, unit};
  end

  assign seq = utt_pkg::utf8_encode(cp);

  // decode of one accepted byte
  always_comb begin
    held_nxt = held_r;
    odd_nxt  = odd_r;
    hp_nxt   = hp_r;
    hb_nxt   = hb_r;
    off_nxt  = off_r;
    skip_nxt = skip_r;
    enc      = 1'b0;
    fail     = 1'b0;
    fcode    = utt_pkg::ERR_NONE;
    foff     = '0;
    if (in_acc) begin
      if (skip_r) begin
        // dropping until the final byte
      end else if (!odd_r) begin
        if (fin) begin
          fail  = 1'b1;
          fcode = utt_pkg::ERR_ODD_LEN;
        end else begin
          held_nxt = b;
          odd_nxt  = 1'b1;
          off_nxt  = off_r + 32'd1;
        end
      end else begin
        odd_nxt  = 1'b0;
        held_nxt = '0;
        off_nxt  = off_r + 32'd1;
        if (hp_r) begin
          if (!is_lo) begin
            fail  = 1'b1;
            fcode = utt_pkg::ERR_BAD_PAIR;
            foff  = off_r - 32'd3;
          end else begin
            enc    = 1'b1;
            hp_nxt = 1'b0;
            hb_nxt = '0;
          end
        end else if (is_hi) begin
          if (fin) begin
            fail  = 1'b1;
            fcode = utt_pkg::ERR_TRUNC;
            foff  = off_r - 32'd1;
          end else begin
            hp_nxt = 1'b1;
            hb_nxt = unit[9:0];
          end
        end else if (is_lo) begin
          fail  = 1'b1;
          fcode = utt_pkg::ERR_LONE_LOW;
          foff  = off_r - 32'd1;
        end else begin
          enc = 1'b1;
        end
      end
      if (fail && !fin) begin
        skip_nxt = 1'b1;
      end
      if (fin) begin
        held_nxt = '0;
        odd_nxt  = 1'b0;
        hp_nxt   = 1'b0;
        hb_nxt   = '0;
        off_nxt  = '0;
        skip_nxt = 1'b0;
      end
    end
  end

  assign has_res = enc || fail;

  // output register: load on a producing byte, shift on each sent request
  always_comb begin
    bv_nxt    = bv_r;
    rem_nxt   = rem_r;
    bytes_nxt = bytes_r;
    done_nxt  = done_r;
    code_nxt  = code_r;
    pos_nxt   = pos_r;
    if (out_acc) begin
      if (rem_r == 2'd0) begin
        bv_nxt = 1'b0;
      end else begin
        rem_nxt   = rem_r - 2'd1;
        bytes_nxt = {8'd0, bytes_r[3:1]};
      end
    end
    if (has_res) begin
      bv_nxt = 1'b1;
      if (fail) begin
        rem_nxt   = 2'd0;
        bytes_nxt = '0;
        done_nxt  = 1'b1;
        code_nxt  = fcode;
        pos_nxt   = start_r + foff;
      end else begin
        rem_nxt   = seq.last;
        bytes_nxt = seq.bytes;
        done_nxt  = fin;
        code_nxt  = utt_pkg::ERR_NONE;
        pos_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= '0;
      odd_r   <= 1'b0;
      hp_r    <= 1'b0;
      hb_r    <= '0;
      off_r   <= '0;
      skip_r  <= 1'b0;
      start_r <= '0;
      bv_r    <= 1'b0;
      rem_r   <= '0;
    end else begin
      held_r <= held_nxt;
      odd_r  <= odd_nxt;
      hp_r   <= hp_nxt;
      hb_r   <= hb_nxt;
      off_r  <= off_nxt;
      skip_r <= skip_nxt;
      bv_r   <= bv_nxt;
      rem_r  <= rem_nxt;
      if (cfg_we) begin
        start_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    done_r  <= done_nxt;
    code_r  <= code_nxt;
    pos_r   <= pos_nxt;
  end

  assign out_chan.valid               = bv_r;
  assign out_chan.data.utf8_byte      = bytes_r[0];
  assign out_chan.data.run_last       = (rem_r == 2'd0);
  assign out_chan.data.text_done      = (rem_r == 2'd0) && done_r;
  assign out_chan.data.error_code     = code_r;
  assign out_chan.data.error_position = pos_r;

  // error requests are always single
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    bv_r && code_r != utt_pkg::ERR_NONE |-> rem_r == 2'd0 && done_r)
    else $error("error request with trailing bytes");

  // final byte returns the text state to idle
  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && fin |=> !odd_r && !hp_r && !skip_r && off_r == 32'd0)
    else $error("text state not cleared after final byte");

  // no held byte outside the high-byte phase
  a_held_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !odd_r |-> held_r == 8'd0)
    else $error("held byte left over");

  // surrogate bits only while a high surrogate is pending
  a_hb_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !hp_r |-> hb_r == 10'd0)
    else $error("stale high surrogate bits");

endmodule
